### src/gat_pkg.sv
// ----------------------------------------------------------------------------
// GF(2) affine transform package
// Shared constants and the per-byte update functions of the generator and
// the checksum.
// ----------------------------------------------------------------------------
package gat_pkg;

    localparam logic [63:0] SEED_RESET      = 64'hCAFEBABEDEADBEEF;
    localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
    // The FNV prime is 2**40 + 0x1b3.
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]  FNV_PRIME_LOW   = 9'h1b3;

    localparam int ROWS      = 128;
    localparam int ROW_W     = 128;
    localparam int ROW_BYTES = 16;
    localparam int MAT_BYTES = ROWS * ROW_BYTES;
    localparam int ALL_BYTES = MAT_BYTES + ROW_BYTES;
    localparam int CNT_W     = $clog2(ALL_BYTES);
    localparam int ROW_AW    = $clog2(ROWS);

    function automatic logic [63:0] xs_next(input logic [63:0] x);
        logic [63:0] v;
        v = x ^ (x << 13);
        v = v ^ (v >> 7);
        v = v ^ (v << 17);
        return v;
    endfunction

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] t;
        logic [63:0] p;
        t = h ^ {56'd0, b};
        p = t * {55'd0, FNV_PRIME_LOW};
        return (t << FNV_PRIME_SHIFT) + p;
    endfunction

endpackage

### src/gat_if.sv
// ----------------------------------------------------------------------------
// GF(2) affine transform channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface gat_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] data_low;
    logic [63:0] data_high;

    modport source (output valid, mode, data_low, data_high, input ready);
    modport sink   (input valid, mode, data_low, data_high, output ready);
endinterface

interface gat_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        check_failed;

    modport source (output valid, result_low, result_high, check_failed, input ready);
    modport sink   (input valid, result_low, result_high, check_failed, output ready);
endinterface

### src/gat_checksum.sv
// ----------------------------------------------------------------------------
// FNV-1a checksum accumulator
// Folds one byte per cycle, while i_step is high, into a 64-bit FNV-1a hash.
// ----------------------------------------------------------------------------
module gat_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_init,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    output logic [63:0] o_hash,
    output logic [63:0] o_hash_next
);

    logic [63:0] r_hash;

    assign o_hash_next = gat_pkg::fnv_step(r_hash, i_byte);
    assign o_hash      = r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= gat_pkg::FNV_BASIS;
        end else if (i_init) begin
            r_hash <= gat_pkg::FNV_BASIS;
        end else if (i_step) begin
            r_hash <= o_hash_next;
        end
    end

endmodule

### src/gf2_affine_transform_128.sv
// ----------------------------------------------------------------------------
// GF(2) affine transform, 128 bits
// Matrix times input over GF(2) plus a translation, with a seeded generator
// and a checksum self check.
// ----------------------------------------------------------------------------
// One request is handled at a time. The first request after reset or after a
// seed write first generates the matrix, one byte per cycle. A transform then
// reads the matrix memory, which delivers one row per cycle; a self check
// folds the matrix and translation into the checksum, one byte per cycle.
// A new request is taken as soon as the previous one has reached the result
// register.
module gf2_affine_transform_128 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [63:0]    i_cfg_wdata,
    gat_req_if.sink        i_req,
    gat_rsp_if.source      o_rsp
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_GEN     = 3'd1;
    localparam logic [2:0] ST_XF_PRE  = 3'd2;
    localparam logic [2:0] ST_XF      = 3'd3;
    localparam logic [2:0] ST_CHK_PRE = 3'd4;
    localparam logic [2:0] ST_CHK     = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    localparam int CW = gat_pkg::CNT_W;
    localparam int AW = gat_pkg::ROW_AW;
    localparam logic [CW-1:0] LAST_BYTE = CW'(gat_pkg::ALL_BYTES - 1);
    localparam logic [CW-1:0] MAT_END   = CW'(gat_pkg::MAT_BYTES);
    localparam logic [AW-1:0] LAST_ROW  = AW'(gat_pkg::ROWS - 1);

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 cnt_inc;
    logic [63:0]                   r_seed;
    logic                          r_gen_flag;
    logic [63:0]                   r_x;
    logic [63:0]                   x_next;
    logic [gat_pkg::ROW_W-1:0]     r_row;
    logic [gat_pkg::ROW_W-1:0]     row_next;
    logic [gat_pkg::ROW_W-1:0]     r_offset;
    logic [63:0]                   r_recorded;
    logic                          r_mode;
    logic [gat_pkg::ROW_W-1:0]     r_data;
    logic [gat_pkg::ROW_W-1:0]     r_acc;
    logic                          r_fail;
    logic [gat_pkg::ROW_W-1:0]     r_mem [0:gat_pkg::ROWS-1];
    logic [gat_pkg::ROW_W-1:0]     r_rdata;
    logic [AW-1:0]                 rd_addr;
    logic                          mem_we;
    logic                          req_fire;
    logic                          slot_free;
    logic                          r_out_valid;
    logic [gat_pkg::ROW_W-1:0]     r_result;
    logic                          r_out_fail;
    logic [7:0]                    chk_byte;
    logic [7:0]                    hash_byte;
    logic                          hash_init;
    logic                          hash_step;
    logic [63:0]                   hash_cur;
    logic [63:0]                   hash_next;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign cnt_inc     = r_cnt + CW'(1);
    assign x_next      = gat_pkg::xs_next(r_x);
    assign row_next    = {x_next[7:0], r_row[gat_pkg::ROW_W-1:8]};
    assign mem_we      = (r_state == ST_GEN) && (r_cnt < MAT_END) && (r_cnt[3:0] == 4'hF);

    always_comb begin
        if (r_state == ST_XF) begin
            rd_addr = cnt_inc[AW-1:0];
        end else if (r_state == ST_CHK) begin
            rd_addr = cnt_inc[AW+3:4];
        end else begin
            rd_addr = '0;
        end
    end

    always_comb begin
        if (r_cnt < MAT_END) begin
            chk_byte = r_rdata[{r_cnt[3:0], 3'b000} +: 8];
        end else begin
            chk_byte = r_offset[{r_cnt[3:0], 3'b000} +: 8];
        end
    end

    assign hash_byte = (r_state == ST_GEN) ? x_next[7:0] : chk_byte;
    assign hash_init = (r_state == ST_IDLE) || (r_state == ST_CHK_PRE);
    assign hash_step = (r_state == ST_GEN) || (r_state == ST_CHK);

    gat_checksum u_checksum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init      (hash_init),
        .i_step      (hash_step),
        .i_byte      (hash_byte),
        .o_hash      (hash_cur),
        .o_hash_next (hash_next)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cnt[AW+3:4]] <= row_next;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    if (!r_gen_flag) begin
                        n_state = ST_GEN;
                    end else if (i_req.mode) begin
                        n_state = ST_CHK_PRE;
                    end else begin
                        n_state = ST_XF_PRE;
                    end
                end
            end
            ST_GEN: begin
                if (r_cnt == LAST_BYTE) begin
                    n_state = r_mode ? ST_CHK_PRE : ST_XF_PRE;
                end
            end
            ST_XF_PRE:  n_state = ST_XF;
            ST_XF: begin
                if (r_cnt[AW-1:0] == LAST_ROW) begin
                    n_state = ST_DONE;
                end
            end
            ST_CHK_PRE: n_state = ST_CHK;
            ST_CHK: begin
                if (r_cnt == LAST_BYTE) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_seed     <= gat_pkg::SEED_RESET;
            r_gen_flag <= 1'b0;
            r_recorded <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_seed     <= i_cfg_wdata;
                r_gen_flag <= 1'b0;
            end else if (r_state == ST_GEN && r_cnt == LAST_BYTE) begin
                r_gen_flag <= 1'b1;
            end
            if (r_state == ST_GEN && r_cnt == LAST_BYTE) begin
                r_recorded <= hash_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state) inside
            ST_IDLE: begin
                r_cnt  <= '0;
                r_x    <= r_seed;
                if (req_fire) begin
                    r_mode <= i_req.mode;
                    r_data <= {i_req.data_high, i_req.data_low};
                end
            end
            ST_GEN: begin
                r_cnt <= cnt_inc;
                r_x   <= x_next;
                r_row <= row_next;
                if (r_cnt == LAST_BYTE) begin
                    r_offset <= row_next;
                end
            end
            ST_XF_PRE, ST_CHK_PRE: begin
                r_cnt <= '0;
            end
            ST_XF: begin
                r_cnt <= cnt_inc;
                r_acc[{r_cnt[AW-1:3], ~r_cnt[2:0]}] <= ^(r_rdata & r_data);
            end
            ST_CHK: begin
                r_cnt <= cnt_inc;
                if (r_cnt == LAST_BYTE) begin
                    r_fail <= (hash_next != r_recorded);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && slot_free) begin
            r_result   <= r_mode ? '0 : (r_acc ^ r_offset);
            r_out_fail <= r_mode & r_fail;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_low   = r_result[63:0];
    assign o_rsp.result_high  = r_result[127:64];
    assign o_rsp.check_failed = r_out_fail;

    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result appeared without a finished request");

    a_fail_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_fail |-> r_result == '0)
        else $error("failed self check carries transform data");

    a_ops_after_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_XF || r_state == ST_CHK) && !$past(i_cfg_we) |-> r_gen_flag)
        else $error("matrix used before generation");

    a_unused_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_XF_PRE |=> hash_cur == $past(hash_cur))
        else $error("checksum moved during a transform");

endmodule

### sim/gf2_affine_transform_128_checker.sv
// ----------------------------------------------------------------------------
// GF(2) affine transform checker
// Watches the seed port and both channels, keeps its own copy of the
// generated matrix, translation and checksum, predicts the result of every
// accepted request and compares each accepted result with the oldest
// prediction field by field.
// ----------------------------------------------------------------------------
module gf2_affine_transform_128_checker #(
    parameter logic CHECK_MODE = 1'b1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    gat_req_if          i_req,
    gat_rsp_if          i_rsp,
    output int          o_pending,
    output int          o_failures
);
    import gat_pkg::*;

    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
        logic        check_failed;
    } affine_result_t;

    logic [63:0]    seed_reg = SEED_RESET;
    logic           generated = 1'b0;
    logic [63:0]    recorded_sum = '0;
    logic [7:0]     store_bytes [0:ALL_BYTES-1];
    logic [127:0]   row_bits [0:ROWS-1];
    logic [127:0]   offset_bits;
    affine_result_t pending_results [$];
    int             mismatches = 0;

    initial o_pending = 0;
    assign o_failures = mismatches;

    function automatic logic [63:0] store_checksum();
        logic [63:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < ALL_BYTES; i++) begin
            h = (h ^ {56'd0, store_bytes[i]}) * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic affine_result_t predict_result(input logic m, input logic [63:0] lo,
                                                      input logic [63:0] hi);
        logic [63:0]    x;
        logic [127:0]   operand;
        logic [127:0]   res;
        int             bit_pos;
        affine_result_t r;
        if (!generated) begin
            x = seed_reg;
            for (int i = 0; i < ALL_BYTES; i++) begin
                x = x ^ (x << 13);
                x = x ^ (x >> 7);
                x = x ^ (x << 17);
                store_bytes[i] = x[7:0];
            end
            for (int row = 0; row < ROWS; row++) begin
                for (int k = 0; k < ROW_BYTES; k++) begin
                    row_bits[row][8*k +: 8] = store_bytes[row*ROW_BYTES + k];
                end
            end
            for (int k = 0; k < ROW_BYTES; k++) begin
                offset_bits[8*k +: 8] = store_bytes[MAT_BYTES + k];
            end
            recorded_sum = store_checksum();
            generated = 1'b1;
        end
        r = '0;
        if (m == CHECK_MODE) begin
            r.check_failed = (store_checksum() != recorded_sum);
        end else begin
            operand = {hi, lo};
            res = offset_bits;
            // Output bit r sits MSB first within its byte.
            for (int row = 0; row < ROWS; row++) begin
                bit_pos = 8*(row/8) + 7 - (row%8);
                res[bit_pos] = res[bit_pos] ^ (^(row_bits[row] & operand));
            end
            r.result_low = res[63:0];
            r.result_high = res[127:64];
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        affine_result_t oldest;
        if (!i_rst_n) begin
            seed_reg = SEED_RESET;
            generated = 1'b0;
            recorded_sum = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                seed_reg = i_cfg_wdata;
                generated = 1'b0;
            end
            if (i_req.valid && i_req.ready) begin
                pending_results.push_back(
                    predict_result(i_req.mode, i_req.data_low, i_req.data_high));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request pending");
                    mismatches++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("result_low", oldest.result_low, i_rsp.result_low);
                    check_field("result_high", oldest.result_high, i_rsp.result_high);
                    check_field("check_failed", {63'd0, oldest.check_failed},
                                {63'd0, i_rsp.check_failed});
                end
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

### sim/gf2_affine_transform_128_test.sv
// ----------------------------------------------------------------------------
// GF(2) affine transform testbench
// Drives directed requests over the data extremes, both modes and the zero and
// all-ones seeds, then random requests under random and reset seeds, idling at
// random on both channels in all but one phase; reports the checker's verdict.
// ----------------------------------------------------------------------------
module gf2_affine_transform_128_test;
    import gat_pkg::*;

    localparam logic TRANSFORM_MODE = 1'b0;
    localparam logic CHECK_MODE     = 1'b1;
    localparam int   STALL_LIMIT    = 20000;
    localparam int   TAIL_CYCLES    = 20;
    localparam int   PHASES         = 5;
    localparam int   PHASE_REQUESTS = 206;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [63:0] cfg_wdata;
    logic        quiet = 1'b0;
    int          pending;
    int          failures;

    gat_req_if req_ch ();
    gat_rsp_if rsp_ch ();

    gf2_affine_transform_128 uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    gf2_affine_transform_128_checker #(.CHECK_MODE(CHECK_MODE)) check_unit (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        rsp_ch.ready <= quiet || ($urandom_range(99) >= 12);
    end

    function automatic logic [63:0] random_word();
        logic [63:0] w;
        case ($urandom_range(7))
            0: begin
                w = '0;
            end
            1: begin
                w = '1;
            end
            2: begin
                w = 64'd1 << $urandom_range(63);
            end
            3: begin
                w = ~(64'd1 << $urandom_range(63));
            end
            default: begin
                w = {$urandom, $urandom};
            end
        endcase
        return w;
    endfunction

    task automatic send_request(input logic m, input logic [63:0] lo, input logic [63:0] hi);
        while (!quiet && $urandom_range(99) < 12) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= m;
        req_ch.data_low <= lo;
        req_ch.data_high <= hi;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_seed(input logic [63:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("gf2_affine_transform_128_test: errors");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = TRANSFORM_MODE;
        req_ch.data_low = '0;
        req_ch.data_high = '0;
        rsp_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first request after reset runs generation under the reset seed.
        send_request(CHECK_MODE, '1, '1);
        send_request(TRANSFORM_MODE, '0, '0);
        send_request(TRANSFORM_MODE, '1, '1);
        send_request(TRANSFORM_MODE, 64'd1, '0);
        send_request(TRANSFORM_MODE, '0, 64'h8000_0000_0000_0000);
        send_request(TRANSFORM_MODE, 64'h8000_0000_0000_0000, 64'd1);
        send_request(TRANSFORM_MODE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(TRANSFORM_MODE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_request(CHECK_MODE, '0, '0);
        send_request(TRANSFORM_MODE, {$urandom, $urandom}, {$urandom, $urandom});

        // A zero seed stays zero, so the matrix and translation are all zero.
        write_seed('0);
        send_request(TRANSFORM_MODE, '1, '1);
        send_request(TRANSFORM_MODE, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        send_request(CHECK_MODE, '0, '0);

        write_seed('1);
        send_request(CHECK_MODE, '0, '1);
        send_request(TRANSFORM_MODE, '1, '1);
        send_request(TRANSFORM_MODE, '0, '0);

        write_seed(64'd1);
        send_request(TRANSFORM_MODE, '1, '0);
        send_request(TRANSFORM_MODE, '0, '1);
        send_request(CHECK_MODE, '1, '0);

        for (int phase = 0; phase < PHASES; phase++) begin
            write_seed((phase == 3) ? SEED_RESET : {$urandom, $urandom});
            quiet = (phase == 2);
            repeat (PHASE_REQUESTS) begin
                send_request(($urandom_range(99) < 3) ? CHECK_MODE : TRANSFORM_MODE,
                             random_word(), random_word());
            end
        end
        quiet = 1'b0;

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0) begin
            $display("gf2_affine_transform_128_test: clean");
        end else begin
            $display("gf2_affine_transform_128_test: errors");
        end
        $finish;
    end

endmodule

### files.f
src/gat_pkg.sv
src/gat_if.sv
src/gat_checksum.sv
src/gf2_affine_transform_128.sv
sim/gf2_affine_transform_128_checker.sv
sim/gf2_affine_transform_128_test.sv
